@@ design/sbs_pkg.sv @@
// shared types, codes and helpers for the surface block shader
// no dependencies; used by sbs_light and surface_block_shader_core
`default_nettype none

package sbs_pkg;

  // defaults for the top-level parameters
  localparam int SHADE_ROWS_DEF     = 64;
  localparam int MAX_BLOCK_SIDE_DEF = 16;

  // fixed field widths
  localparam int LIGHT_W  = 14;
  localparam int TEXEL_W  = 8;
  localparam int TIDX_W   = 14;
  localparam int TVAL_W   = 8;
  localparam int FUNC_W   = 2;
  localparam int MIP_W    = 2;
  localparam int FIX_W    = 16;
  localparam int COUNT_W  = 4;
  localparam int SHIFT_W  = 3;
  localparam int PIXEL_W  = 8;

  // input tdata layout, lowest bit first
  localparam int TL_LSB   = 0;
  localparam int TR_LSB   = TL_LSB + LIGHT_W;
  localparam int BL_LSB   = TR_LSB + LIGHT_W;
  localparam int BR_LSB   = BL_LSB + LIGHT_W;
  localparam int TEX_LSB  = BR_LSB + LIGHT_W;
  localparam int TIDX_LSB = TEX_LSB + TEXEL_W;
  localparam int TVAL_LSB = TIDX_LSB + TIDX_W;
  localparam int IN_BITS  = TVAL_LSB + TVAL_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // item kinds carried on in_tuser; code 3 is dropped
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_TEXEL = 2'd1,
    FUNC_WRITE = 2'd2
  } func_t;

  // per-pixel position flags
  typedef struct packed {
    logic row_end;
    logic block_end;
  } sbs_flags_t;

  // arithmetic shift right of a 16-bit two's complement value
  function automatic logic [FIX_W-1:0] asr16(input logic [FIX_W-1:0] v,
                                              input logic [SHIFT_W-1:0] sh);
    logic signed [FIX_W-1:0] s;
    s = $signed(v);
    return FIX_W'(s >>> sh);
  endfunction

endpackage

`default_nettype wire

@@ design/sbs_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module sbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/sbs_light.sv @@
// light interpolation state: edge lights, run light, row and column counts
// depends on sbs_pkg
`default_nettype none

module sbs_light #(
  parameter int SHADE_ROWS     = sbs_pkg::SHADE_ROWS_DEF,
  parameter int MAX_BLOCK_SIDE = sbs_pkg::MAX_BLOCK_SIDE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [sbs_pkg::MIP_W-1:0]        mip_level,
  input  wire logic                             load,
  input  wire logic                             shade,
  input  wire logic [sbs_pkg::LIGHT_W-1:0]      light_top_left,
  input  wire logic [sbs_pkg::LIGHT_W-1:0]      light_top_right,
  input  wire logic [sbs_pkg::LIGHT_W-1:0]      light_bottom_left,
  input  wire logic [sbs_pkg::LIGHT_W-1:0]      light_bottom_right,
  output logic      [$clog2(SHADE_ROWS)-1:0]    shade_row,
  output sbs_pkg::sbs_flags_t                   flags
);

  localparam int ROW_W = $clog2(SHADE_ROWS);
  localparam int FW    = sbs_pkg::FIX_W;
  localparam int CW    = sbs_pkg::COUNT_W;
  localparam int SW    = sbs_pkg::SHIFT_W;
  localparam logic [SW-1:0] MAX_LOG = SW'($clog2(MAX_BLOCK_SIDE + 1) - 1);
  localparam logic [8:0]    ROWS9   = 9'(SHADE_ROWS);

  logic [FW-1:0] edge_left_r, edge_left_nxt;
  logic [FW-1:0] edge_right_r, edge_right_nxt;
  logic [FW-1:0] left_step_r, left_step_nxt;
  logic [FW-1:0] right_step_r, right_step_nxt;
  logic [FW-1:0] run_light_r, run_light_nxt;
  logic [FW-1:0] run_step_r, run_step_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;

  logic [4:0]    side;
  logic [CW-1:0] side_m1;
  logic [SW-1:0] shift;
  logic [8:0]    row_red;

  // block side and division shift for the current mip level
  always_comb begin
    side    = 5'(MAX_BLOCK_SIDE) >> mip_level;
    side_m1 = (side == 5'd0) ? '0 : CW'(side - 5'd1);
    shift   = ({1'b0, mip_level} > MAX_LOG) ? '0 : MAX_LOG - {1'b0, mip_level};
  end

  // light bits 15..8 folded into the table rows
  always_comb begin
    row_red = {1'b0, run_light_r[15:8]};
    for (int i = 0; i < 8; i++) begin
      if (row_red >= ROWS9) begin
        row_red = row_red - ROWS9;
      end
    end
    shade_row = row_red[ROW_W-1:0];
  end

  assign flags.row_end   = (col_r == '0);
  assign flags.block_end = (col_r == '0) && (row_r >= side_m1);

  always_comb begin
    edge_left_nxt  = edge_left_r;
    edge_right_nxt = edge_right_r;
    left_step_nxt  = left_step_r;
    right_step_nxt = right_step_r;
    run_light_nxt  = run_light_r;
    run_step_nxt   = run_step_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    if (load) begin
      edge_left_nxt  = FW'(light_top_left);
      edge_right_nxt = FW'(light_top_right);
      left_step_nxt  = sbs_pkg::asr16(FW'(light_bottom_left) - FW'(light_top_left), shift);
      right_step_nxt = sbs_pkg::asr16(FW'(light_bottom_right) - FW'(light_top_right), shift);
      row_nxt        = '0;
      run_light_nxt  = FW'(light_top_right);
      run_step_nxt   = sbs_pkg::asr16(FW'(light_top_left) - FW'(light_top_right), shift);
      col_nxt        = side_m1;
    end else if (shade) begin
      if (col_r == '0) begin
        // row done: step edges, open the next row
        edge_left_nxt  = edge_left_r + left_step_r;
        edge_right_nxt = edge_right_r + right_step_r;
        row_nxt        = flags.block_end ? '0 : row_r + CW'(1);
        run_light_nxt  = edge_right_nxt;
        run_step_nxt   = sbs_pkg::asr16(edge_left_nxt - edge_right_nxt, shift);
        col_nxt        = side_m1;
      end else begin
        run_light_nxt  = run_light_r + run_step_r;
        col_nxt        = col_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_left_r  <= '0;
      edge_right_r <= '0;
      left_step_r  <= '0;
      right_step_r <= '0;
      run_light_r  <= '0;
      run_step_r   <= '0;
      col_r        <= '0;
      row_r        <= '0;
    end else begin
      edge_left_r  <= edge_left_nxt;
      edge_right_r <= edge_right_nxt;
      left_step_r  <= left_step_nxt;
      right_step_r <= right_step_nxt;
      run_light_r  <= run_light_nxt;
      run_step_r   <= run_step_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/surface_block_shader_core.sv @@
// surface block shader top level: item decode, shade table, output stage
// depends on sbs_pkg, sbs_ram and sbs_light
`default_nettype none

// Shades a square texture block with bilinear lightmap light. Items on the
// input stream are told apart by in_tuser: a corner load sets up the edge
// lights and steps, a texel item returns one shaded pixel, a table write
// stores one shade table entry. Texels of a block row arrive from the
// rightmost column to the leftmost; each pixel carries tlast at its row's
// end and tuser at the block's end. The block takes one item every clock
// unless a stalled output holds the read stage; a pixel passes through the
// shade table's registered read port, then the output register. The shade
// table holds no defined contents after reset and needs no clearing: every
// entry that is looked up must be written first. The user writes the mip
// level via the cfg port while no item is in flight, unchecked by the block.

module surface_block_shader_core #(
  parameter int SHADE_ROWS     = sbs_pkg::SHADE_ROWS_DEF,
  parameter int MAX_BLOCK_SIDE = sbs_pkg::MAX_BLOCK_SIDE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration: mip level
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sbs_pkg::MIP_W-1:0]       cfg_data,
  // input items
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // light_top_left, light_top_right, light_bottom_left, light_bottom_right,
  // texel, table_index, table_value, then zero fill
  input  wire logic [sbs_pkg::IN_DATA_W-1:0]   in_tdata,
  // func
  input  wire logic [sbs_pkg::FUNC_W-1:0]      in_tuser,
  // result items
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // shaded_pixel
  output logic      [sbs_pkg::PIXEL_W-1:0]     out_tdata,
  // row_end
  output logic                                 out_tlast,
  // block_end
  output logic                                 out_tuser
);

  localparam int TABLE_DEPTH = SHADE_ROWS * 256;
  localparam int ROW_W       = $clog2(SHADE_ROWS);
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int PW          = sbs_pkg::PIXEL_W;

  logic [sbs_pkg::MIP_W-1:0] mip_r;

  logic                      accept;
  logic                      is_load;
  logic                      is_texel;
  logic                      is_write;
  logic [ROW_W-1:0]          shade_row;
  sbs_pkg::sbs_flags_t       flags;

  logic [16:0]               widx;
  logic                      wr_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic [PW-1:0]             rd_data;

  // read stage: texel looked up, data sits in the ram output register
  logic                      s1_valid_r, s1_valid_nxt;
  sbs_pkg::sbs_flags_t       s1_flags_r;
  logic                      move;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [PW-1:0]             out_pixel_r;
  sbs_pkg::sbs_flags_t       out_flags_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mip_r <= '0;
    end else if (cfg_valid) begin
      mip_r <= cfg_data;
    end
  end

  // item decode
  assign accept   = in_tvalid && in_tready;
  assign is_load  = accept && (in_tuser == sbs_pkg::FUNC_LOAD);
  assign is_texel = accept && (in_tuser == sbs_pkg::FUNC_TEXEL);
  assign is_write = accept && (in_tuser == sbs_pkg::FUNC_WRITE);

  sbs_light #(
    .SHADE_ROWS     (SHADE_ROWS),
    .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE)
  ) u_light (
    .clk                (clk),
    .rst_n              (rst_n),
    .mip_level          (mip_r),
    .load               (is_load),
    .shade              (is_texel),
    .light_top_left     (in_tdata[sbs_pkg::TL_LSB +: sbs_pkg::LIGHT_W]),
    .light_top_right    (in_tdata[sbs_pkg::TR_LSB +: sbs_pkg::LIGHT_W]),
    .light_bottom_left  (in_tdata[sbs_pkg::BL_LSB +: sbs_pkg::LIGHT_W]),
    .light_bottom_right (in_tdata[sbs_pkg::BR_LSB +: sbs_pkg::LIGHT_W]),
    .shade_row          (shade_row),
    .flags              (flags)
  );

  // table writes beyond the table are dropped
  assign widx    = 17'(in_tdata[sbs_pkg::TIDX_LSB +: sbs_pkg::TIDX_W]);
  assign wr_en   = is_write && (widx < 17'(TABLE_DEPTH));
  assign rd_addr = {shade_row, in_tdata[sbs_pkg::TEX_LSB +: sbs_pkg::TEXEL_W]};

  sbs_ram #(
    .WIDTH (PW),
    .DEPTH (TABLE_DEPTH)
  ) u_shade_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (widx[ADDR_W-1:0]),
    .wr_data (in_tdata[sbs_pkg::TVAL_LSB +: sbs_pkg::TVAL_W]),
    .rd_en   (is_texel),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // the read stage moves on when the output register is free or draining;
  // while it holds, the ram read port is frozen and no item is taken
  assign move      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || move;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (is_texel) begin
      s1_valid_nxt = 1'b1;
    end else if (move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (is_texel) begin
      s1_flags_r <= flags;
    end
    if (move) begin
      out_pixel_r <= rd_data;
      out_flags_r <= s1_flags_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tlast  = out_flags_r.row_end;
  assign out_tuser  = out_flags_r.block_end;

endmodule

`default_nettype wire
